// ===== hw/rtl/shns_pkg.sv =====
// Shared types and constants for the sorted held-note stack.
// Used by shns_seq and sorted_held_note_stack; no dependencies.
`timescale 1ns / 1ps

package shns_pkg;

    // Default list depth
    localparam int DEPTH_DEF = 8;

    // Field widths
    localparam int NOTE_W  = 7;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 4;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Stream widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Result of one transaction
    typedef struct packed {
        logic [COUNT_W-1:0] held_count;
        logic               top_valid;
        logic [NOTE_W-1:0]  top_note;
    } t_res;

endpackage

// ===== hw/rtl/shns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module shns_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/shns_seq.sv =====
// Sequencer for the sorted note list: scans, shifts and places entries
// one at a time through a shared compare unit. Uses shns_pkg and shns_ram.
`timescale 1ns / 1ps

module shns_seq
    import shns_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_op,
    input  logic [NOTE_W-1:0] i_note,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_res              o_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN_RD  = 7'b0000010,
        ST_SCAN_CMP = 7'b0000100,
        ST_SHIFT_RD = 7'b0001000,
        ST_SHIFT_WR = 7'b0010000,
        ST_PLACE    = 7'b0100000,
        ST_DONE     = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [NOTE_W-1:0] r_note, n_note;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic [NOTE_W-1:0] r_top;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [NOTE_W-1:0] wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [NOTE_W-1:0] rd_data;

    logic [CW-1:0]     idx_inc, idx_dec, count_dec, new_count, shift_top;
    logic              full, cmp_eq, cmp_lt;
    logic [CW+COUNT_W-1:0] count_ext;

    shns_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Shared compare unit and cursor arithmetic
    assign cmp_eq    = (rd_data == r_note);
    assign cmp_lt    = (rd_data < r_note);
    assign idx_inc   = r_idx + CW'(1);
    assign idx_dec   = r_idx - CW'(1);
    assign count_dec = r_count - CW'(1);
    assign full      = (r_count == CW'(DEPTH));
    assign new_count = full ? r_count : r_count + CW'(1);
    assign shift_top = full ? count_dec : r_count;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_note  = r_note;
        n_count = r_count;
        n_idx   = r_idx;
        n_pos   = r_pos;
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = r_idx[IW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op   = i_op;
                    n_note = i_note;
                    n_idx  = '0;
                    n_pos  = '0;
                    case (i_op)
                        OP_PRESS:   n_state = (r_count == '0) ? ST_PLACE : ST_SCAN_RD;
                        OP_RELEASE: n_state = (r_count == '0) ? ST_DONE : ST_SCAN_RD;
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                rd_en   = 1'b1;
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (r_op == OP_PRESS) begin
                    if (cmp_eq) begin
                        n_state = ST_DONE;
                    end else if (cmp_lt) begin
                        // Insert here; open a gap from the tail down
                        n_pos   = r_idx;
                        n_idx   = shift_top;
                        n_state = (shift_top == r_idx) ? ST_PLACE : ST_SHIFT_RD;
                    end else begin
                        n_idx = idx_inc;
                        if (idx_inc == r_count) begin
                            // Lower than every entry: append or drop
                            n_pos   = idx_inc;
                            n_state = full ? ST_DONE : ST_PLACE;
                        end else begin
                            n_state = ST_SCAN_RD;
                        end
                    end
                end else begin
                    if (cmp_eq) begin
                        if (r_idx == count_dec) begin
                            n_count = count_dec;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_SHIFT_RD;
                        end
                    end else begin
                        n_idx   = idx_inc;
                        n_state = (idx_inc == r_count) ? ST_DONE : ST_SCAN_RD;
                    end
                end
            end
            ST_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_addr = (r_op == OP_PRESS) ? idx_dec[IW-1:0] : idx_inc[IW-1:0];
                n_state = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                wr_en = 1'b1;
                if (r_op == OP_PRESS) begin
                    n_idx   = idx_dec;
                    n_state = (idx_dec == r_pos) ? ST_PLACE : ST_SHIFT_RD;
                end else begin
                    n_idx = idx_inc;
                    if (idx_inc == count_dec) begin
                        n_count = count_dec;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SHIFT_RD;
                    end
                end
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IW-1:0];
                wr_data = r_note;
                n_count = new_count;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_note <= n_note;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
    end

    // Shadow copy of the head entry
    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == '0)) begin
            r_top <= wr_data;
        end
    end

    // Result
    assign count_ext        = {{COUNT_W{1'b0}}, r_count};
    assign o_idle           = (r_state == ST_IDLE);
    assign o_res_valid      = (r_state == ST_DONE);
    assign o_res.top_valid  = (r_count != '0);
    assign o_res.top_note   = (r_count != '0) ? r_top : '0;
    assign o_res.held_count = count_ext[COUNT_W-1:0];

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("note count exceeds depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && i_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the list");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_res_ready) |=> (r_state == ST_IDLE))
        else $error("result handoff did not return to idle");

    a_place_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PLACE) |=> (r_count != '0 && r_state == ST_DONE))
        else $error("placed note left list empty");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ({1'b0, wr_addr} < (IW + 1)'(DEPTH)))
        else $error("write beyond list end");

endmodule

// ===== hw/rtl/sorted_held_note_stack.sv =====
// Top level of the sorted held-note stack: stream ports and result register.
// Depends on shns_pkg, shns_seq and shns_ram.
//
//  Channel  Dir  Handshake          Payload
//  s_axis   in   tvalid / tready    tdata[1:0] opcode, tdata[8:2] note
//  m_axis   out  tvalid / tready    tdata[6:0] top_note, [7] top_valid, [11:8] held_count
//
// A transaction walks the list one entry at a time through one RAM port pair:
// each entry scanned or shifted passes a read state and a compare or write state
// (never more than DEPTH entries in all); then a press that adds its note places
// it, the result is handed over and the sequencer returns to idle. Clear and
// unused opcodes go straight to the hand-over. Reset clears the count; there is
// no clearing pass. s_axis_tready is high whenever the sequencer
// is idle, also while an earlier result still waits in the output register; a
// finished result holds the sequencer until that register frees up.
`timescale 1ns / 1ps

module sorted_held_note_stack
    import shns_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [1:0] opcode, [8:2] note
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [6:0] top_note, [7] top_valid,
                                                 // [11:8] held_count
);

    logic   seq_idle;
    logic   seq_res_valid;
    logic   seq_res_ready;
    t_res   seq_res;
    logic   r_m_valid;
    t_res   r_m_res;

    shns_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid && seq_idle),
        .i_op        (s_axis_tdata[OP_W-1:0]),
        .i_note      (s_axis_tdata[OP_W+NOTE_W-1:OP_W]),
        .o_idle      (seq_idle),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_res       (seq_res)
    );

    assign s_axis_tready = seq_idle;
    assign seq_res_ready = !r_m_valid || m_axis_tready;

    // Output register: load a finished result, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (seq_res_valid && seq_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (seq_res_valid && seq_res_ready) begin
            r_m_res <= seq_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - NOTE_W - 1 - COUNT_W){1'b0}},
                            r_m_res.held_count, r_m_res.top_valid, r_m_res.top_note};

endmodule
